// ===== hdl/wrp_pkg.sv =====
// ---------------------------------------------------------------------------
// wrp_pkg: shared types and constants of the wav riff chunk parser
// parse phases, event and error codes, chunk tags, state and result records
// ---------------------------------------------------------------------------
package wrp_pkg;

  // parse phases, one-hot
  typedef enum logic [10:0] {
    PH_RIFF = 11'b000_0000_0001,
    PH_SIZE = 11'b000_0000_0010,
    PH_WAVE = 11'b000_0000_0100,
    PH_HDR  = 11'b000_0000_1000,
    PH_FMT  = 11'b000_0001_0000,
    PH_FACT = 11'b000_0010_0000,
    PH_SKIP = 11'b000_0100_0000,
    PH_DATA = 11'b000_1000_0000,
    PH_PAD  = 11'b001_0000_0000,
    PH_DONE = 11'b010_0000_0000,
    PH_ERR  = 11'b100_0000_0000
  } phase_t;

  // result event codes
  localparam logic [2:0] EV_HEADER  = 3'd0;
  localparam logic [2:0] EV_PAYLOAD = 3'd1;
  localparam logic [2:0] EV_LAST    = 3'd2;
  localparam logic [2:0] EV_ERROR   = 3'd3;
  localparam logic [2:0] EV_IDLE    = 3'd4;

  // error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_RIFF_ID  = 3'd1;
  localparam logic [2:0] ERR_WAVE     = 3'd2;
  localparam logic [2:0] ERR_OVERRUN  = 3'd3;
  localparam logic [2:0] ERR_EARLY    = 3'd4;
  localparam logic [2:0] ERR_NO_DATA  = 3'd5;

  // chunk ids as little-endian words
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_FACT = 32'h7463_6166;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  // header field lengths
  localparam logic [31:0] ID_BYTES  = 32'd4;
  localparam logic [31:0] HDR_BYTES = 32'd8;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] field_offset;
    logic [32:0] file_position;
    logic [32:0] riff_limit;
    logic [31:0] chunk_length;
    logic [31:0] chunk_tag;
    logic [31:0] assembly_shift;
    logic [15:0] extension_length;
    logic [15:0] held_format;
    logic [15:0] held_channels;
    logic [31:0] held_rate;
    logic [31:0] held_byte_rate;
    logic [15:0] held_align;
    logic [15:0] held_depth;
    logic [15:0] held_valid_depth;
    logic [31:0] held_mask;
    logic [31:0] held_sample_count;
    logic [31:0] payload_remaining;
    logic [2:0]  latched_error;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase: PH_RIFF,
    default: '0
  };

  typedef struct packed {
    logic [2:0]  event_res;
    logic [2:0]  error_code;
    logic [7:0]  payload_byte;
    logic [15:0] fmt_tag;
    logic [15:0] channel_count;
    logic [31:0] rate_hz;
    logic [31:0] data_rate;
    logic [15:0] frame_bytes;
    logic [15:0] sample_bits;
    logic [15:0] valid_bits;
    logic [31:0] speaker_mask;
    logic [31:0] sample_total;
  } result_t;

  // or a byte into lane k of a little-endian word
  function automatic logic [31:0] put32(logic [31:0] v, logic [7:0] b, logic [1:0] k);
    return v | ({24'd0, b} << {k, 3'b000});
  endfunction

  function automatic logic [15:0] put16(logic [15:0] v, logic [7:0] b, logic k);
    return v | ({8'd0, b} << {k, 3'b000});
  endfunction

endpackage

// ===== hdl/wrp_intf.sv =====
// ---------------------------------------------------------------------------
// wrp_intf: channel interfaces of the wav riff chunk parser
// byte feed channel and decoded result channel, valid/ready handshake
// ---------------------------------------------------------------------------
interface wrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output first_byte, output last_byte,
                  input ready);
  modport sink (input valid, input in_byte, input first_byte, input last_byte,
                output ready);
endinterface

interface wrp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [2:0]  error_code;
  logic [7:0]  payload_byte;
  logic [15:0] fmt_tag;
  logic [15:0] channel_count;
  logic [31:0] rate_hz;
  logic [31:0] data_rate;
  logic [15:0] frame_bytes;
  logic [15:0] sample_bits;
  logic [15:0] valid_bits;
  logic [31:0] speaker_mask;
  logic [31:0] sample_total;

  modport source (output valid, output event_res, output error_code, output payload_byte,
                  output fmt_tag, output channel_count, output rate_hz,
                  output data_rate, output frame_bytes, output sample_bits,
                  output valid_bits, output speaker_mask, output sample_total,
                  input ready);
  modport sink (input valid, input event_res, input error_code, input payload_byte,
                input fmt_tag, input channel_count, input rate_hz,
                input data_rate, input frame_bytes, input sample_bits,
                input valid_bits, input speaker_mask, input sample_total,
                output ready);
endinterface

// ===== hdl/wrp_step.sv =====
// ---------------------------------------------------------------------------
// wrp_step: one-byte parse step
// next parse state and the result word for one file byte
// ---------------------------------------------------------------------------
module wrp_step (
  input  wrp_pkg::state_t  st,
  input  logic [7:0]       in_byte,
  input  logic             first_byte,
  input  logic             last_byte,
  output wrp_pkg::state_t  nxt,
  output wrp_pkg::result_t res
);

  // next chunk header if it can still start inside the riff body
  function automatic wrp_pkg::state_t chunk_start(wrp_pkg::state_t x, logic ok);
    wrp_pkg::state_t y;
    y = x;
    if (ok) begin
      y.phase          = wrp_pkg::PH_HDR;
      y.field_offset   = '0;
      y.chunk_tag      = '0;
      y.assembly_shift = '0;
    end else begin
      y.phase         = wrp_pkg::PH_ERR;
      y.latched_error = wrp_pkg::ERR_NO_DATA;
    end
    return y;
  endfunction

  function automatic wrp_pkg::state_t body_end(wrp_pkg::state_t x, logic ok);
    wrp_pkg::state_t y;
    y = x;
    if (x.phase == wrp_pkg::PH_DATA) begin
      y.phase = wrp_pkg::PH_DONE;
    end else if (x.chunk_length[0]) begin
      y.phase = wrp_pkg::PH_PAD;
    end else begin
      y = chunk_start(x, ok);
    end
    return y;
  endfunction

  wrp_pkg::state_t s;
  wrp_pkg::state_t n;
  logic [33:0]     fp_inc;
  logic            start_ok;
  logic            overrun;
  logic [31:0]     off_inc;
  logic [31:0]     shift_new;
  logic [31:0]     rem;
  logic [2:0]      ev;
  logic [7:0]      pay;

  always_comb begin
    s         = first_byte ? wrp_pkg::STATE_RESET : st;
    n         = s;
    ev        = wrp_pkg::EV_HEADER;
    pay       = '0;
    fp_inc    = {1'b0, s.file_position} + 34'd1;
    off_inc   = s.field_offset + 32'd1;
    start_ok  = ({1'b0, fp_inc} + 35'd4) < {2'b00, s.riff_limit};
    shift_new = wrp_pkg::put32(s.assembly_shift, in_byte, s.field_offset[1:0]);
    overrun   = ({3'b000, shift_new} + {1'b0, fp_inc}) > {2'b00, s.riff_limit};
    rem       = s.payload_remaining - 32'd1;

    unique case (s.phase)
      wrp_pkg::PH_RIFF, wrp_pkg::PH_WAVE: begin
        n.chunk_tag     = wrp_pkg::put32(s.chunk_tag, in_byte, s.field_offset[1:0]);
        n.field_offset  = off_inc;
        n.file_position = fp_inc[32:0];
        if (off_inc == wrp_pkg::ID_BYTES) begin
          if (s.phase == wrp_pkg::PH_RIFF) begin
            if (n.chunk_tag != wrp_pkg::TAG_RIFF) begin
              n.phase         = wrp_pkg::PH_ERR;
              n.latched_error = wrp_pkg::ERR_RIFF_ID;
            end else begin
              n.phase          = wrp_pkg::PH_SIZE;
              n.field_offset   = '0;
              n.assembly_shift = '0;
            end
          end else begin
            if (n.chunk_tag != wrp_pkg::TAG_WAVE) begin
              n.phase         = wrp_pkg::PH_ERR;
              n.latched_error = wrp_pkg::ERR_WAVE;
            end else begin
              n = chunk_start(n, start_ok);
            end
          end
        end
      end
      wrp_pkg::PH_SIZE: begin
        n.assembly_shift = shift_new;
        n.field_offset   = off_inc;
        n.file_position  = fp_inc[32:0];
        if (off_inc == wrp_pkg::ID_BYTES) begin
          n.riff_limit   = {1'b0, shift_new} + 33'd8;
          n.phase        = wrp_pkg::PH_WAVE;
          n.field_offset = '0;
          n.chunk_tag    = '0;
        end
      end
      wrp_pkg::PH_HDR: begin
        if (s.field_offset < wrp_pkg::ID_BYTES) begin
          n.chunk_tag = wrp_pkg::put32(s.chunk_tag, in_byte, s.field_offset[1:0]);
        end else begin
          n.assembly_shift = shift_new;
        end
        n.field_offset  = off_inc;
        n.file_position = fp_inc[32:0];
        if (off_inc == wrp_pkg::HDR_BYTES) begin
          n.field_offset = '0;
          if (overrun) begin
            n.phase         = wrp_pkg::PH_ERR;
            n.latched_error = wrp_pkg::ERR_OVERRUN;
          end else begin
            n.chunk_length = shift_new;
            priority if (s.chunk_tag == wrp_pkg::TAG_FMT) begin
              n.held_format      = '0;
              n.held_channels    = '0;
              n.held_align       = '0;
              n.held_depth       = '0;
              n.held_valid_depth = '0;
              n.held_rate        = '0;
              n.held_byte_rate   = '0;
              n.held_mask        = '0;
              n.extension_length = '0;
              n.phase            = wrp_pkg::PH_FMT;
            end else if (s.chunk_tag == wrp_pkg::TAG_FACT) begin
              n.held_sample_count = '0;
              n.phase             = wrp_pkg::PH_FACT;
            end else if (s.chunk_tag == wrp_pkg::TAG_DATA) begin
              n.payload_remaining = shift_new;
              n.phase             = wrp_pkg::PH_DATA;
            end else begin
              n.phase = wrp_pkg::PH_SKIP;
            end
            if (shift_new == '0) begin
              n = body_end(n, start_ok);
            end
          end
        end
      end
      wrp_pkg::PH_FMT, wrp_pkg::PH_FACT, wrp_pkg::PH_SKIP: begin
        if (s.phase == wrp_pkg::PH_FMT) begin
          // fmt fields by byte offset into the body
          priority if (s.field_offset < 32'd2) begin
            n.held_format = wrp_pkg::put16(s.held_format, in_byte, s.field_offset[0]);
          end else if (s.field_offset < 32'd4) begin
            n.held_channels = wrp_pkg::put16(s.held_channels, in_byte, s.field_offset[0]);
          end else if (s.field_offset < 32'd8) begin
            n.held_rate = wrp_pkg::put32(s.held_rate, in_byte, s.field_offset[1:0]);
          end else if (s.field_offset < 32'd12) begin
            n.held_byte_rate = wrp_pkg::put32(s.held_byte_rate, in_byte,
                                              s.field_offset[1:0]);
          end else if (s.field_offset < 32'd14) begin
            n.held_align = wrp_pkg::put16(s.held_align, in_byte, s.field_offset[0]);
          end else if (s.field_offset < 32'd16) begin
            n.held_depth = wrp_pkg::put16(s.held_depth, in_byte, s.field_offset[0]);
          end else if (s.field_offset < 32'd18) begin
            n.extension_length = wrp_pkg::put16(s.extension_length, in_byte,
                                                s.field_offset[0]);
          end else if (s.extension_length != '0) begin
            if (s.field_offset < 32'd20) begin
              n.held_valid_depth = wrp_pkg::put16(s.held_valid_depth, in_byte,
                                                  s.field_offset[0]);
            end else if (s.field_offset < 32'd24) begin
              n.held_mask = wrp_pkg::put32(s.held_mask, in_byte, s.field_offset[1:0]);
            end
          end
        end else if (s.phase == wrp_pkg::PH_FACT && s.field_offset < wrp_pkg::ID_BYTES) begin
          n.held_sample_count = wrp_pkg::put32(s.held_sample_count, in_byte,
                                               s.field_offset[1:0]);
        end
        n.field_offset  = off_inc;
        n.file_position = fp_inc[32:0];
        if (off_inc >= s.chunk_length) begin
          n = body_end(n, start_ok);
        end
      end
      wrp_pkg::PH_DATA: begin
        pay                 = in_byte;
        n.payload_remaining = rem;
        n.file_position     = fp_inc[32:0];
        if (rem == '0) begin
          ev      = wrp_pkg::EV_LAST;
          n.phase = wrp_pkg::PH_DONE;
        end else begin
          ev = wrp_pkg::EV_PAYLOAD;
        end
      end
      wrp_pkg::PH_PAD: begin
        n.file_position = fp_inc[32:0];
        n = chunk_start(n, start_ok);
      end
      wrp_pkg::PH_DONE: begin
        ev = wrp_pkg::EV_IDLE;
      end
      default: begin
        n.phase = wrp_pkg::PH_ERR;
      end
    endcase

    // file ends before the data body is through
    if (last_byte && n.phase != wrp_pkg::PH_DONE && n.phase != wrp_pkg::PH_ERR) begin
      n.phase         = wrp_pkg::PH_ERR;
      n.latched_error = wrp_pkg::ERR_EARLY;
    end

    res                 = '0;
    res.event_res       = ev;
    res.error_code      = wrp_pkg::ERR_NONE;
    res.payload_byte    = pay;
    if (n.phase == wrp_pkg::PH_ERR) begin
      res.event_res    = wrp_pkg::EV_ERROR;
      res.error_code   = n.latched_error;
      res.payload_byte = '0;
    end
    res.fmt_tag         = n.held_format;
    res.channel_count   = n.held_channels;
    res.rate_hz         = n.held_rate;
    res.data_rate       = n.held_byte_rate;
    res.frame_bytes     = n.held_align;
    res.sample_bits     = n.held_depth;
    res.valid_bits      = n.held_valid_depth;
    res.speaker_mask    = n.held_mask;
    res.sample_total    = n.held_sample_count;
    nxt                 = n;
  end

endmodule

// ===== hdl/wav_riff_chunk_parser.sv =====
// ---------------------------------------------------------------------------
// wav_riff_chunk_parser: riff/wave header parser with data passthrough
// walks a wav file one byte a cycle barring result stalls and passes the data chunk out
// ---------------------------------------------------------------------------
// The parser takes one file byte per word on the feed channel and returns
// exactly one result word per byte, in the next cycle, at a sustained rate
// of one byte per clock barring result stalls: the whole step for a byte is
// a single pass through the step logic between the parse state registers
// and the result register, the longest path being a 35-bit add and compare
// on the chunk bounds. The feed is ready whenever the result register is
// empty or being taken in the same cycle, so a stall on the result side
// holds back at most one word. Each result word carries an event
// (header/skipped byte, payload byte, last payload byte, error, finished),
// the error code while in error, the payload byte for data chunk bytes, and
// the fmt, extension and fact fields decoded so far. A word flagged
// first_byte restarts parsing at that byte; after an error or the end of
// the data chunk every byte reports that outcome until the next first_byte.
module wav_riff_chunk_parser (
  input  logic      clk,
  input  logic      rst,
  wrp_in_if.sink    feed,
  wrp_out_if.source result
);

  wrp_pkg::state_t  state;
  wrp_pkg::state_t  state_next;
  wrp_pkg::result_t res_next;
  wrp_pkg::result_t res;
  logic             res_valid;
  logic             accept;

  // one byte in per cycle unless a result is stuck in the output register
  assign feed.ready = !res_valid || result.ready;
  assign accept     = feed.valid && feed.ready;

  wrp_step u_step (
    .st         (state),
    .in_byte    (feed.in_byte),
    .first_byte (feed.first_byte),
    .last_byte  (feed.last_byte),
    .nxt        (state_next),
    .res        (res_next)
  );

  // parse state, advanced once per accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wrp_pkg::STATE_RESET;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // result register and its valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign result.valid           = res_valid;
  assign result.event_res       = res.event_res;
  assign result.error_code      = res.error_code;
  assign result.payload_byte    = res.payload_byte;
  assign result.fmt_tag         = res.fmt_tag;
  assign result.channel_count   = res.channel_count;
  assign result.rate_hz         = res.rate_hz;
  assign result.data_rate       = res.data_rate;
  assign result.frame_bytes     = res.frame_bytes;
  assign result.sample_bits     = res.sample_bits;
  assign result.valid_bits      = res.valid_bits;
  assign result.speaker_mask    = res.speaker_mask;
  assign result.sample_total    = res.sample_total;

  // every accepted byte leaves a result word behind
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> result.valid)
    else $error("no result word after an accepted byte");

  // error code is set exactly on error events
  a_error_code: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> ((result.event_res == wrp_pkg::EV_ERROR) ==
                      (result.error_code != wrp_pkg::ERR_NONE)))
    else $error("error code and event disagree");

  // payload byte only on data events
  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.event_res != wrp_pkg::EV_PAYLOAD &&
     result.event_res != wrp_pkg::EV_LAST) |-> (result.payload_byte == 8'd0))
    else $error("payload byte outside a data event");

  // finished stays finished until a new file starts
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    (state.phase == wrp_pkg::PH_DONE && !(accept && feed.first_byte))
      |=> (state.phase == wrp_pkg::PH_DONE))
    else $error("left the finished phase without a new file");

endmodule
